[rtl/core/lfu_cache_policy_core_defines.svh]
// assertion helpers for the lfu core
`ifndef LFU_CACHE_POLICY_CORE_DEFINES_SVH
`define LFU_CACHE_POLICY_CORE_DEFINES_SVH

// same-cycle implication
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/lfu_pkg.sv]
`default_nettype none

package lfu_pkg;

  localparam int CAP_W             = 5;
  localparam int DEFAULT_ENTRIES   = 16;
  localparam int DEFAULT_COUNT_W   = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] req_key;
    logic signed [31:0] req_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic found;
    logic free_any;
    logic victim_any;
  } scan_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

[rtl/core/lfu_scan.sv]
`default_nettype none

module lfu_scan
  import lfu_pkg::*;
#(
  parameter int ENTRIES     = DEFAULT_ENTRIES,
  parameter int COUNT_WIDTH = DEFAULT_COUNT_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   step,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] step_idx,
  input  logic                   step_entry_valid,
  input  logic signed [31:0]     ent_key,
  input  logic signed [31:0]     ent_value,
  input  logic [COUNT_WIDTH-1:0] ent_count,
  input  logic [31:0]            ent_stamp,
  input  logic signed [31:0]     req_key,
  input  logic [31:0]            stamp_now,
  output scan_flags_t            flags,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] found_idx,
  output logic signed [31:0]     found_value,
  output logic [COUNT_WIDTH-1:0] found_count,
  output logic [31:0]            found_stamp,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] victim_idx,
  output logic signed [31:0]     victim_key
);

  logic [COUNT_WIDTH-1:0] best_count;
  logic [31:0]            best_age;
  logic [31:0]            age;
  logic                   take_victim;

  assign age = stamp_now - ent_stamp;

  always_comb begin
    take_victim = !flags.victim_any || (ent_count < best_count) ||
                  ((ent_count == best_count) && (age > best_age));
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (step) begin
      if (step_entry_valid) begin
        if (!flags.found && (ent_key == req_key)) begin
          flags.found <= 1'b1;
        end
        if (take_victim) begin
          flags.victim_any <= 1'b1;
        end
      end else if (!flags.free_any) begin
        flags.free_any <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && step_entry_valid) begin
      if (!flags.found && (ent_key == req_key)) begin
        found_idx   <= step_idx;
        found_value <= ent_value;
        found_count <= ent_count;
        found_stamp <= ent_stamp;
      end
      if (take_victim) begin
        victim_idx <= step_idx;
        victim_key <= ent_key;
        best_count <= ent_count;
        best_age   <= age;
      end
    end
    if (step && !step_entry_valid && !flags.free_any) begin
      free_idx <= step_idx;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lfu_cache_policy_core.sv]
// lfu key-value store, up to ENTRIES entries
// in channel (in_valid/in_ready/in_data): one get or put request per beat
// out channel (out_valid/out_ready/out_data): one response beat per request
// cfg channel (cfg_valid/cfg_ready/cfg_data): active capacity, taken only while
// idle with no request offered
// a request walks the entry memory once through one compare unit that finds
// the key, the first free slot and the lfu victim, then does the write-back
// and loads the response; with capacity zero the walk is skipped and the
// request goes straight from the accept to the write-back
// the memory read port, one entry per cycle, paces the walk
// one request is in flight at a time; a response waiting in the output
// register does not block the next accept, but the write-back of the next
// request holds until that response beat is taken
// reset clears the valid bits, fill count and stamp and sets capacity to 16;
// no clearing pass is needed
`default_nettype none

module lfu_cache_policy_core
  import lfu_pkg::*;
#(
  parameter int ENTRIES     = DEFAULT_ENTRIES,
  parameter int COUNT_WIDTH = DEFAULT_COUNT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

`include "lfu_cache_policy_core_defines.svh"

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);

  state_t state, state_next;

  logic [CAP_W-1:0]  active_capacity;
  logic [FILL_W-1:0] cap_eff;
  logic              cap_zero;
  logic [FILL_W-1:0] fill_count;
  logic [31:0]       access_stamp;
  logic [ENTRIES-1:0] entry_valid;

  req_t              req;
  logic              req_cap_zero;
  logic [FILL_W-1:0] rd_idx;
  logic              step_valid;
  logic [IDX_W-1:0]  step_idx;

  logic signed [31:0]     mem_key   [ENTRIES];
  logic signed [31:0]     mem_value [ENTRIES];
  logic [COUNT_WIDTH-1:0] mem_count [ENTRIES];
  logic [31:0]            mem_stamp [ENTRIES];

  logic signed [31:0]     rd_key;
  logic signed [31:0]     rd_value;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [31:0]            rd_stamp;

  logic in_fire;
  logic rd_en;
  logic load_out;

  scan_flags_t            flags;
  logic [IDX_W-1:0]       found_idx;
  logic signed [31:0]     found_value;
  logic [COUNT_WIDTH-1:0] found_count;
  logic [31:0]            found_stamp;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       victim_idx;
  logic signed [31:0]     victim_key;

  logic                   live_found;
  logic                   need_evict;
  logic                   do_evict;
  logic                   do_insert;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic signed [31:0]     wr_value;
  logic [COUNT_WIDTH-1:0] wr_count;
  logic [31:0]            wr_stamp;
  rsp_t                   rsp;

  // effective capacity
  always_comb begin
    if (32'(active_capacity) > 32'(ENTRIES)) begin
      cap_eff = FILL_W'(ENTRIES);
    end else begin
      cap_eff = FILL_W'(active_capacity);
    end
  end
  assign cap_zero  = (active_capacity == '0);
  assign cfg_ready = (state == ST_IDLE) && !in_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = cap_zero ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx == FILL_W'(ENTRIES)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    in_fire  = in_valid && (state == ST_IDLE);
    rd_en    = (state == ST_SCAN) && (rd_idx != FILL_W'(ENTRIES));
    load_out = (state == ST_UPDATE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      active_capacity <= CAP_RESET;
      fill_count      <= '0;
      access_stamp    <= '0;
      entry_valid     <= '0;
      out_valid       <= 1'b0;
      step_valid      <= 1'b0;
      rd_idx          <= '0;
    end else begin
      state      <= state_next;
      step_valid <= rd_en;
      if (cfg_valid && cfg_ready) begin
        active_capacity <= cfg_data;
      end
      if (in_fire) begin
        rd_idx <= '0;
        if (!cap_zero) begin
          access_stamp <= access_stamp + 32'd1;
        end
      end else if (rd_en) begin
        rd_idx <= rd_idx + FILL_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_out && do_insert) begin
        entry_valid[wr_idx] <= 1'b1;
        if (!do_evict) begin
          fill_count <= fill_count + FILL_W'(1);
        end else if (fill_count == '0) begin
          fill_count <= FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req          <= in_data;
      req_cap_zero <= cap_zero;
    end
    step_idx <= rd_idx[IDX_W-1:0];
    if (load_out) begin
      out_data <= rsp;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_idx]   <= req.req_key;
      mem_value[wr_idx] <= wr_value;
      mem_count[wr_idx] <= wr_count;
      mem_stamp[wr_idx] <= wr_stamp;
    end
    if (rd_en) begin
      rd_key   <= mem_key[rd_idx[IDX_W-1:0]];
      rd_value <= mem_value[rd_idx[IDX_W-1:0]];
      rd_count <= mem_count[rd_idx[IDX_W-1:0]];
      rd_stamp <= mem_stamp[rd_idx[IDX_W-1:0]];
    end
  end

  lfu_scan #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk              (clk),
    .rst              (rst),
    .start            (in_fire),
    .step             (step_valid),
    .step_idx         (step_idx),
    .step_entry_valid (entry_valid[step_idx]),
    .ent_key          (rd_key),
    .ent_value        (rd_value),
    .ent_count        (rd_count),
    .ent_stamp        (rd_stamp),
    .req_key          (req.req_key),
    .stamp_now        (access_stamp),
    .flags            (flags),
    .found_idx        (found_idx),
    .found_value      (found_value),
    .found_count      (found_count),
    .found_stamp      (found_stamp),
    .free_idx         (free_idx),
    .victim_idx       (victim_idx),
    .victim_key       (victim_key)
  );

  // write-back and response
  always_comb begin
    live_found = flags.found && !req_cap_zero;
    need_evict = (fill_count >= cap_eff) || !flags.free_any;
    do_evict   = !req_cap_zero && (req.req_type == REQ_PUT) && !flags.found &&
                 need_evict && flags.victim_any;
    do_insert  = !req_cap_zero && (req.req_type == REQ_PUT) && !flags.found &&
                 (do_evict || flags.free_any);
    wr_en      = load_out && (live_found || do_insert);

    if (live_found) begin
      wr_idx   = found_idx;
      wr_value = (req.req_type == REQ_PUT) ? req.req_value : found_value;
      if (&found_count) begin
        wr_count = found_count;
        wr_stamp = found_stamp;
      end else begin
        wr_count = found_count + COUNT_WIDTH'(1);
        wr_stamp = access_stamp;
      end
    end else begin
      wr_idx   = do_evict ? victim_idx : free_idx;
      wr_value = req.req_value;
      wr_count = COUNT_WIDTH'(1);
      wr_stamp = access_stamp;
    end

    rsp.hit         = live_found;
    rsp.read_value  = (live_found && (req.req_type == REQ_GET)) ? found_value : 32'sd0;
    rsp.evicted     = do_evict;
    rsp.evicted_key = do_evict ? victim_key : 32'sd0;
  end

  `LFU_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= FILL_W'(ENTRIES), "fill count above entries")
  `LFU_ASSERT_NOW(a_evict_miss, out_valid && out_data.evicted, !out_data.hit, "eviction on a hit")
  `LFU_ASSERT_NOW(a_value_hit, out_valid && (out_data.read_value != 0), out_data.hit, "value without hit")
  `LFU_ASSERT_NEXT(a_stamp_step, in_valid && in_ready && !cap_zero, access_stamp == $past(access_stamp) + 32'd1, "stamp did not advance")

endmodule

`default_nettype wire
